### rtl/bbpe_pkg.sv
// Shared types, constants and codes of the byte-level BPE character codec.
package bbpe_pkg;

   localparam int DATA_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int LEAD_W      = 5;
   localparam int CP_W        = 11;
   localparam int RSP_DEPTH   = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // Register word index taken from paddr[2]
   localparam logic CSR_DIRECTION_IDX = 1'b0;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_CONT  = 3'd1,
      ST_LEAD_LONG = 3'd2,
      ST_UNMAPPED  = 3'd3,
      ST_TRUNCATED = 3'd4
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      status_type        status;
      logic              last_of_run;
      logic              end_of_string;
   } rsp_beat_type;

   typedef struct packed {
      logic [1:0]        push_cnt;
      rsp_beat_type      beat0;
      rsp_beat_type      beat1;
      logic              lead_pending;
      logic [LEAD_W-1:0] lead_bits;
   } xlate_result_type;

endpackage

### rtl/bbpe_if.sv
// Valid/ready channel interfaces for input bytes and result bytes.
interface bbpe_req_if;
   logic                        valid;
   logic                        ready;
   logic [bbpe_pkg::DATA_W-1:0] data_byte;
   logic                        string_end;

   modport source (output valid, output data_byte, output string_end, input ready);
   modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface bbpe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bbpe_pkg::DATA_W-1:0]   out_byte;
   logic [bbpe_pkg::STATUS_W-1:0] status;
   logic                          last_of_run;
   logic                          end_of_string;

   modport source (output valid, output out_byte, output status, output last_of_run,
                   output end_of_string, input ready);
   modport sink   (input valid, input out_byte, input status, input last_of_run,
                   input end_of_string, output ready);
endinterface

### rtl/byte_level_bpe_char_codec.sv
// Top level of the byte-level BPE character codec (GPT-2 byte map, UTF-8).
// An accepted input beat is translated combinationally; its result beats are registered in the result queue.
// Throughput: one input beat per cycle while each byte yields at most one result and
//   the result port is ready; an encoded byte with a code point above 0x7f yields two
//   result beats, and the single result port then holds back the input.
// Reset: synchronous, active high; clears direction (encode), the held lead and the queue.
module byte_level_bpe_char_codec #(
   parameter int RspDepth = bbpe_pkg::RSP_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   bbpe_req_if.sink                        req_chan,
   bbpe_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bbpe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bbpe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bbpe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import bbpe_pkg::*;

   // Configuration and decoder state
   logic              direction_ff;
   logic              lead_pending_ff;
   logic [LEAD_W-1:0] lead_bits_ff;

   logic              cfg_wr;
   logic              req_acc;
   logic              room_ok;
   logic [1:0]        push_cnt;
   xlate_result_type  xl;

   // APB-style port: zero wait states, one register at word 0
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CSR_DIRECTION_IDX);
   assign prdata = (paddr[2] == CSR_DIRECTION_IDX) ? {{(CSR_DATA_W-1){1'b0}}, direction_ff}
                                                   : '0;

   // Take a beat only when the queue can absorb the worst case of two results,
   // so the queue never overflows; results left waiting can still hold back input beats.
   assign req_chan.ready = room_ok;
   assign req_acc        = req_chan.valid && req_chan.ready;

   // Map/encode or decode the incoming byte against the held lead
   bbpe_xlate u_xlate (
      .direction    (direction_ff),
      .data_byte    (req_chan.data_byte),
      .string_end   (req_chan.string_end),
      .lead_pending (lead_pending_ff),
      .lead_bits    (lead_bits_ff),
      .result       (xl)
   );

   // Push nothing unless the beat is actually taken
   assign push_cnt = req_acc ? xl.push_cnt : 2'd0;

   bbpe_rsp_fifo #(
      .Depth (RspDepth)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .beat0    (xl.beat0),
      .beat1    (xl.beat1),
      .room_ok  (room_ok),
      .rsp_chan (rsp_chan)
   );

   // A direction write drops any held lead; otherwise advance the lead on each beat
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff    <= DIR_ENCODE;
         lead_pending_ff <= 1'b0;
         lead_bits_ff    <= '0;
      end else if (cfg_wr) begin
         direction_ff    <= pwdata[0];
         lead_pending_ff <= 1'b0;
         lead_bits_ff    <= '0;
      end else if (req_acc) begin
         lead_pending_ff <= xl.lead_pending;
         lead_bits_ff    <= xl.lead_bits;
      end
   end

   // A lead is only ever held while decoding
   a_lead_only_decode: assert property (@(posedge clock) disable iff (reset)
      lead_pending_ff |-> (direction_ff == DIR_DECODE))
      else $error("lead held in encode direction");

   // Every encoded byte yields at least one result beat
   a_encode_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (direction_ff == DIR_ENCODE)) |-> (xl.push_cnt != 2'd0))
      else $error("encoded byte produced no result");

   // A direction write leaves no lead behind
   a_cfg_clears_lead: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !lead_pending_ff)
      else $error("lead survived a direction write");

   // Error beats carry a zero byte and always close their run
   a_error_beat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != ST_OK)) |->
         ((rsp_chan.out_byte == '0) && rsp_chan.last_of_run))
      else $error("error beat with data or open run");

endmodule

### rtl/bbpe_xlate.sv
// Per-byte mapping and UTF-8 encode/decode logic of the codec.
module bbpe_xlate (
   input  logic                        direction,
   input  logic [bbpe_pkg::DATA_W-1:0] data_byte,
   input  logic                        string_end,
   input  logic                        lead_pending,
   input  logic [bbpe_pkg::LEAD_W-1:0] lead_bits,
   output bbpe_pkg::xlate_result_type  result
);
   import bbpe_pkg::*;

   logic [8:0]      enc_cp;
   logic [CP_W-1:0] dec_cp;

   // Forward byte map: control and high-control ranges and 0xad move above 0xff
   always_comb begin
      if (data_byte inside {[8'h00:8'h20]}) begin
         enc_cp = {1'b1, data_byte};
      end else if (data_byte inside {[8'h7f:8'ha0]}) begin
         enc_cp = {1'b0, data_byte} + 9'h0a2;
      end else if (data_byte == 8'had) begin
         enc_cp = 9'h143;
      end else begin
         enc_cp = {1'b0, data_byte};
      end
   end

   assign dec_cp = {lead_bits, data_byte[5:0]};

   always_comb begin
      result              = '0;
      result.lead_pending = lead_pending;
      result.lead_bits    = lead_bits;
      result.beat0.last_of_run   = 1'b1;
      result.beat0.end_of_string = string_end;
      result.beat0.status        = ST_OK;
      result.beat1.status        = ST_OK;
      if (direction == DIR_ENCODE) begin
         if (enc_cp <= 9'h07f) begin
            result.push_cnt       = 2'd1;
            result.beat0.out_byte = enc_cp[7:0];
         end else begin
            // Two-byte UTF-8: lead then continuation
            result.push_cnt             = 2'd2;
            result.beat0.out_byte       = 8'hc0 + {5'd0, enc_cp[8:6]};
            result.beat0.last_of_run    = 1'b0;
            result.beat0.end_of_string  = 1'b0;
            result.beat1.out_byte       = {2'b10, enc_cp[5:0]};
            result.beat1.last_of_run    = 1'b1;
            result.beat1.end_of_string  = string_end;
         end
      end else if (lead_pending) begin
         result.push_cnt     = 2'd1;
         result.lead_pending = 1'b0;
         result.lead_bits    = '0;
         if (data_byte[7:6] != 2'b10) begin
            result.beat0.status = ST_BAD_CONT;
         end else if (dec_cp inside {[11'h100:11'h120]}) begin
            result.beat0.out_byte = dec_cp[7:0];
         end else if (dec_cp inside {[11'h121:11'h142]}) begin
            result.beat0.out_byte = dec_cp[7:0] + 8'h5e;
         end else if (dec_cp == 11'h143) begin
            result.beat0.out_byte = 8'had;
         end else if (dec_cp >= 11'h100) begin
            result.beat0.status = ST_UNMAPPED;
         end else begin
            result.beat0.out_byte = dec_cp[7:0];
         end
      end else if (!data_byte[7]) begin
         result.push_cnt       = 2'd1;
         result.beat0.out_byte = data_byte;
      end else if (data_byte[7:5] == 3'b110) begin
         if (string_end) begin
            result.push_cnt     = 2'd1;
            result.beat0.status = ST_TRUNCATED;
         end else begin
            // Hold the lead; no result for this byte
            result.push_cnt     = 2'd0;
            result.lead_pending = 1'b1;
            result.lead_bits    = data_byte[4:0];
         end
      end else begin
         result.push_cnt     = 2'd1;
         result.beat0.status = ST_LEAD_LONG;
      end
   end

endmodule

### rtl/bbpe_rsp_fifo.sv
// Result queue: takes up to two beats per cycle, sends one beat per cycle while the receiver is ready.
module bbpe_rsp_fifo #(
   parameter int Depth = bbpe_pkg::RSP_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_cnt,
   input  bbpe_pkg::rsp_beat_type beat0,
   input  bbpe_pkg::rsp_beat_type beat1,
   output logic                  room_ok,
   bbpe_rsp_if.source            rsp_chan
);
   import bbpe_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   rsp_beat_type    mem_ff [Depth];
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] wr_ptr_nx;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr_nx = ptr_inc(wr_ptr_ff);
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign room_ok   = count_ff <= CntW'(Depth - 2);

   assign rsp_chan.valid         = count_ff != '0;
   assign rsp_chan.out_byte      = mem_ff[rd_ptr_ff].out_byte;
   assign rsp_chan.status        = mem_ff[rd_ptr_ff].status;
   assign rsp_chan.last_of_run   = mem_ff[rd_ptr_ff].last_of_run;
   assign rsp_chan.end_of_string = mem_ff[rd_ptr_ff].end_of_string;

   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push_cnt)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CntW'(push_cnt) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= beat0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_nx] <= beat1;
      end
   end

endmodule
